// ===== hdl/pps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_RAN      = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [31:0] arrival;
    logic [31:0] response;
    logic        started;
  } slot_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  run_id;
    logic [31:0] time_now;
    logic        finished;
    logic [31:0] response_time;
    logic [31:0] waiting_time;
  } res_t;

  typedef enum logic [2:0] {
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_CUR,
    WR_RDATA,
    WR_BEST
  } wr_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_TK_ROOT,
    S_TK_LAST,
    S_DN_L,
    S_DN_LW,
    S_DN_RW,
    S_DN_DEC,
    S_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    up_step;
    logic    take_root;
    logic    load_last;
    logic    save_left;
    logic    pick_right;
    logic    dn_step;
    logic    run;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic in_tick;
    logic full;
    logic empty;
    logic pos_zero;
    logic parent_le;
    logic has_left;
    logic has_right;
    logic multi;
    logic again;
    logic best_valid;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/pps_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  process_id;
  logic [7:0]  prio_level;
  logic [15:0] burst_length;

  modport source (output valid, req_type, process_id, prio_level, burst_length, input ready);
  modport sink (input valid, req_type, process_id, prio_level, burst_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/pps_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  run_id;
  logic [31:0] time_now;
  logic        finished;
  logic [31:0] response_time;
  logic [31:0] waiting_time;

  modport source (output valid, status, run_id, time_now, finished, response_time,
                  waiting_time, input ready);
  modport sink (input valid, status, run_id, time_now, finished, response_time,
                waiting_time, output ready);
endinterface
`default_nettype wire

// ===== hdl/pps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/pps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pps_ctrl
  import pps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t st,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!st.in_tick) state_nxt = st.full ? S_DONE : S_UP_CHK;
          else state_nxt = st.empty ? S_DONE : S_TK_ROOT;
        end
      end
      S_UP_CHK:  state_nxt = st.pos_zero ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_nxt = st.parent_le ? S_DONE : S_UP_CHK;
      S_TK_ROOT: state_nxt = st.multi ? S_TK_LAST : S_RUN;
      S_TK_LAST: state_nxt = S_DN_L;
      S_DN_L:    state_nxt = st.has_left ? S_DN_LW : S_RUN;
      S_DN_LW:   state_nxt = st.has_right ? S_DN_RW : S_DN_DEC;
      S_DN_RW:   state_nxt = S_DN_DEC;
      S_DN_DEC:  state_nxt = st.best_valid ? S_DN_L : S_RUN;
      S_RUN:     state_nxt = st.again ? S_UP_CHK : S_DONE;
      S_DONE:    state_nxt = st.out_free ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_ROOT;
    cmd.wr_sel = WR_CUR;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
        cmd.rd_en = in_valid && st.in_tick && !st.empty;
      end
      S_UP_CHK: begin
        if (st.pos_zero) begin
          cmd.wr_en = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_PARENT;
        end
      end
      S_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (!st.parent_le) begin
          cmd.wr_sel = WR_RDATA;
          cmd.up_step = 1'b1;
        end
      end
      S_TK_ROOT: begin
        cmd.take_root = 1'b1;
        cmd.rd_en = st.multi;
        cmd.rd_sel = RD_LAST;
      end
      S_TK_LAST: cmd.load_last = 1'b1;
      S_DN_L: begin
        if (st.has_left) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_LEFT;
        end else begin
          cmd.wr_en = 1'b1;
        end
      end
      S_DN_LW: begin
        cmd.save_left = 1'b1;
        cmd.rd_en = st.has_right;
        cmd.rd_sel = RD_RIGHT;
      end
      S_DN_RW: cmd.pick_right = 1'b1;
      S_DN_DEC: begin
        cmd.wr_en = 1'b1;
        if (st.best_valid) begin
          cmd.wr_sel = WR_BEST;
          cmd.dn_step = 1'b1;
        end
      end
      S_RUN:  cmd.run = 1'b1;
      S_DONE: cmd.out_load = st.out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/pps_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pps_dpath
  import pps_pkg::*;
#(
  parameter int HEAP_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            st,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_process_id,
  input  wire logic [7:0]  in_prio_level,
  input  wire logic [15:0] in_burst_length,
  input  wire logic        out_ready,
  output logic             out_valid,
  output res_t             out_res
);
  localparam int IW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int SW = $bits(slot_t);

  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   time_r, time_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic          best_valid_r, best_valid_nxt;
  slot_t         cur_r, cur_nxt;
  slot_t         m_r, m_nxt;
  slot_t         best_r, best_nxt;
  res_t          res_r, res_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  slot_t         rdata;
  logic [SW-1:0] rd_raw;
  slot_t         wdata;
  logic [IW-1:0] rd_addr;
  logic [CW:0]   left_w, right_w;
  logic [IW-1:0] parent_w, last_w;
  slot_t         new_slot, m_upd;
  logic [15:0]   burst_fix;
  logic [7:0]    best_prio;

  assign rdata    = slot_t'(rd_raw);
  assign left_w   = (CW+1)'({pos_r, 1'b1});
  assign right_w  = left_w + (CW+1)'(1);
  assign parent_w = IW'((pos_r - IW'(1)) >> 1);
  assign last_w   = IW'(count_r - CW'(1));
  assign burst_fix = (in_burst_length == 16'd0) ? 16'd1 : in_burst_length;
  assign best_prio = best_valid_r ? best_r.prio : cur_r.prio;

  always_comb begin
    new_slot = '0;
    new_slot.id = in_process_id;
    new_slot.prio = in_prio_level;
    new_slot.remaining = burst_fix;
    new_slot.burst = burst_fix;
    new_slot.arrival = time_r;
  end

  always_comb begin
    m_upd = m_r;
    m_upd.started = 1'b1;
    if (!m_r.started) m_upd.response = now_r - m_r.arrival;
    m_upd.remaining = m_r.remaining - 16'd1;
  end

  always_comb begin
    st.in_tick    = in_req_type;
    st.full       = count_r >= CW'(HEAP_DEPTH);
    st.empty      = count_r == '0;
    st.pos_zero   = pos_r == '0;
    st.parent_le  = rdata.prio <= cur_r.prio;
    st.has_left   = left_w < {1'b0, count_r};
    st.has_right  = right_w < {1'b0, count_r};
    st.multi      = count_r >= CW'(2);
    st.again      = m_upd.remaining != 16'd0;
    st.best_valid = best_valid_r;
    st.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = last_w;
      RD_PARENT: rd_addr = parent_w;
      RD_LEFT:   rd_addr = left_w[IW-1:0];
      RD_RIGHT:  rd_addr = right_w[IW-1:0];
      default:   rd_addr = '0;
    endcase
    case (cmd.wr_sel)
      WR_CUR:   wdata = cur_r;
      WR_RDATA: wdata = rdata;
      WR_BEST:  wdata = best_r;
      default:  wdata = cur_r;
    endcase
  end

  pps_ram #(.WIDTH(SW), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (pos_r),
    .wr_data (wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    count_nxt = count_r;
    time_nxt = time_r;
    now_nxt = now_r;
    pos_nxt = pos_r;
    best_idx_nxt = best_idx_r;
    best_valid_nxt = best_valid_r;
    cur_nxt = cur_r;
    m_nxt = m_r;
    best_nxt = best_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;

    if (cmd.accept) begin
      now_nxt = time_r;
      res_nxt = '0;
      res_nxt.time_now = time_r;
      if (!in_req_type) begin
        res_nxt.run_id = in_process_id;
        if (st.full) begin
          res_nxt.status = ST_DROPPED;
        end else begin
          res_nxt.status = ST_ACCEPTED;
          cur_nxt = new_slot;
          pos_nxt = IW'(count_r);
          count_nxt = count_r + CW'(1);
        end
      end else begin
        time_nxt = time_r + 32'd1;
        res_nxt.status = ST_IDLE;
      end
    end
    if (cmd.up_step) pos_nxt = parent_w;
    if (cmd.take_root) begin
      m_nxt = rdata;
      count_nxt = count_r - CW'(1);
    end
    if (cmd.load_last) begin
      cur_nxt = rdata;
      pos_nxt = '0;
    end
    if (cmd.save_left) begin
      best_nxt = rdata;
      best_idx_nxt = left_w[IW-1:0];
      best_valid_nxt = rdata.prio < cur_r.prio;
    end
    if (cmd.pick_right && (rdata.prio < best_prio)) begin
      best_nxt = rdata;
      best_idx_nxt = right_w[IW-1:0];
      best_valid_nxt = 1'b1;
    end
    if (cmd.dn_step) pos_nxt = best_idx_r;
    if (cmd.run) begin
      res_nxt.status = ST_RAN;
      res_nxt.run_id = m_r.id;
      if (m_upd.remaining != 16'd0) begin
        // put the process back at the tail and sift it up
        cur_nxt = m_upd;
        pos_nxt = IW'(count_r);
        count_nxt = count_r + CW'(1);
      end else begin
        res_nxt.finished = 1'b1;
        res_nxt.response_time = m_upd.response;
        res_nxt.waiting_time = now_r + 32'd1 - m_r.arrival - {16'd0, m_r.burst};
      end
    end
    if (cmd.out_load) begin
      out_nxt = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      time_r <= time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    pos_r <= pos_nxt;
    best_idx_r <= best_idx_nxt;
    best_valid_r <= best_valid_nxt;
    cur_r <= cur_nxt;
    m_r <= m_nxt;
    best_r <= best_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res = out_r;
endmodule
`default_nettype wire

// ===== hdl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    req_type, process_id, prio_level, burst_length
// out_if    out  valid/ready    status, run_id, time_now, finished,
//                               response_time, waiting_time
//
// One request at a time. Each heap step of an arrive or a tick waits on the
// single read port of the heap RAM, whose read data is registered.
// Reset clears the heap count and the time counter; the heap RAM is not cleared.
// A finished result holds in the output register while a new request is worked
// on; the next result waits until that one is taken, accepting no request.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int HEAP_DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pps_in_if.sink    in_if,
  pps_out_if.source out_if
);
  cmd_t  cmd;
  stat_t st;
  res_t  res;
  logic  ready;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (ready),
    .st       (st),
    .cmd      (cmd)
  );

  pps_dpath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (in_if.req_type),
    .in_process_id   (in_if.process_id),
    .in_prio_level   (in_if.prio_level),
    .in_burst_length (in_if.burst_length),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_res         (res)
  );

  assign in_if.ready          = ready;
  assign out_if.status        = res.status;
  assign out_if.run_id        = res.run_id;
  assign out_if.time_now      = res.time_now;
  assign out_if.finished      = res.finished;
  assign out_if.response_time = res.response_time;
  assign out_if.waiting_time  = res.waiting_time;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_if.valid)
    else $error("loaded result not presented");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("new request accepted while one is in work");

  a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> !cmd.wr_en)
    else $error("heap read and write in the same cycle");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.run && st.again) |-> !st.full)
    else $error("reinsert into a full heap");
endmodule
`default_nettype wire
